@@ rtl/smix_pkg.sv @@
package smix_pkg;

  // Default sizes
  localparam int VOICES_DEF    = 8;
  localparam int SLOTS_DEF     = 6;
  localparam int MEM_DEPTH_DEF = 262144;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int SLOT_W = 3;
  localparam int ADDR_W = 18;
  localparam int LEN_W  = 19;
  localparam int SMP_W  = 16;
  localparam int ACT_W  = 4;
  localparam int DROP_W = 32;

  // Mixing arithmetic: Q1.15 sample times Q16 gain, sum in units of 2^-31
  localparam int GAIN_W = 17;
  localparam int PROD_W = SMP_W + GAIN_W;
  localparam int ACC_W  = 40;
  localparam logic signed [GAIN_W-1:0] GAIN_Q16 = 17'sd42598;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEFINE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TRIG   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

endpackage

@@ rtl/smix_addr_mod.sv @@
module smix_addr_mod #(
  parameter int MEM_DEPTH = smix_pkg::MEM_DEPTH_DEF,
  parameter int AW        = $clog2(MEM_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [smix_pkg::ADDR_W-1:0] addr_in,
  output logic                       done,
  output logic [AW-1:0]              result
);
  import smix_pkg::*;

  // Quotient bits of the largest input address over the depth
  localparam int QB    = $clog2(((2 ** ADDR_W) - 1) / MEM_DEPTH + 1);
  localparam int STEPS = (QB < 1) ? 1 : QB;
  localparam int CMPW  = ((AW > ADDR_W) ? AW : ADDR_W) + STEPS;
  localparam int KW    = $clog2(STEPS + 1);

  logic              running;
  logic [KW-1:0]     kcnt;
  logic [ADDR_W-1:0] rem;
  logic [CMPW-1:0]   msh;
  logic              fits;

  assign fits   = CMPW'(rem) >= msh;
  assign result = AW'(rem);

  // Restoring reduction: one shifted copy of the depth tried per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        rem     <= addr_in;
        msh     <= CMPW'(MEM_DEPTH) << (STEPS - 1);
        kcnt    <= KW'(STEPS);
      end else if (running) begin
        if (fits) begin
          rem <= rem - ADDR_W'(msh);
        end
        msh  <= msh >> 1;
        kcnt <= kcnt - KW'(1);
        if (kcnt == KW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/smix_sample_mem.sv @@
module smix_sample_mem #(
  parameter int MEM_DEPTH = smix_pkg::MEM_DEPTH_DEF,
  parameter int AW        = $clog2(MEM_DEPTH)
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic signed [smix_pkg::SMP_W-1:0] wr_data,
  input  logic [AW-1:0]                    rd_addr,
  output logic signed [smix_pkg::SMP_W-1:0] rd_data
);
  import smix_pkg::*;

  logic signed [SMP_W-1:0] mem [MEM_DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/smix_voice_mem.sv @@
module smix_voice_mem #(
  parameter int VOICES = smix_pkg::VOICES_DEF,
  parameter int AW     = $clog2(smix_pkg::MEM_DEPTH_DEF),
  parameter int VIW    = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [VIW-1:0]             wr_idx,
  input  logic [AW-1:0]              wr_addr,
  input  logic [smix_pkg::LEN_W-1:0] wr_rem,
  input  logic [VIW-1:0]             rd_idx,
  output logic [AW-1:0]              rd_addr,
  output logic [smix_pkg::LEN_W-1:0] rd_rem
);
  import smix_pkg::*;

  // Read pointer and frames left per voice, packed in one entry
  logic [AW+LEN_W-1:0] mem [VOICES];
  logic [AW+LEN_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_addr, wr_rem};
    end
    rd_word <= mem[rd_idx];
  end

  assign rd_addr = rd_word[AW+LEN_W-1:LEN_W];
  assign rd_rem  = rd_word[LEN_W-1:0];

endmodule

@@ rtl/sample_voice_allocator_mixer.sv @@
// Polyphonic one-shot sample player and mixer.
// Command channel: a word is taken on a rising edge with start high and
// busy low. Commands load a sample word, define a slot, trigger a slot onto
// the lowest free voice, tick one output frame, or clear all voices.
// Result channel: every command gives one result, shown for one cycle with
// done high; the receiver cannot stall it. busy drops in the done cycle, so
// the next command may be taken there.
// Steps from acceptance to done:
//   trigger, clear, unused codes: the execute state.
//   load, define: the address reduction, run by the one-step-per-cycle
//     modulo unit, then the result.
//   tick: each voice costs one voice-state memory read, and the reads
//     stream through a four-stage chain of state read, sample read,
//     multiply and accumulate.
// One command is in flight at a time.
// Reset clears voices, slot valid bits and the drop total. Sample memory is
// not cleared and must be written before a voice plays it.
module sample_voice_allocator_mixer #(
  parameter int VOICES    = smix_pkg::VOICES_DEF,
  parameter int SLOTS     = smix_pkg::SLOTS_DEF,
  parameter int MEM_DEPTH = smix_pkg::MEM_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [smix_pkg::CMD_W-1:0]        command,
  input  logic [smix_pkg::SLOT_W-1:0]       slot,
  input  logic [smix_pkg::ADDR_W-1:0]       address,
  input  logic [smix_pkg::LEN_W-1:0]        length,
  input  logic signed [smix_pkg::SMP_W-1:0] sample_value,
  input  logic signed [smix_pkg::SMP_W-1:0] music_left,
  input  logic signed [smix_pkg::SMP_W-1:0] music_right,
  output logic                              done,
  output logic signed [smix_pkg::SMP_W-1:0] mix_left,
  output logic signed [smix_pkg::SMP_W-1:0] mix_right,
  output logic                              cue_dropped,
  output logic [smix_pkg::ACT_W-1:0]        active_voices,
  output logic [smix_pkg::DROP_W-1:0]       dropped_count
);
  import smix_pkg::*;

  localparam int AW     = $clog2(MEM_DEPTH);
  localparam int VIW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SIW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW   = $clog2(VOICES + 1);
  localparam int SHR_W  = ACC_W - 16;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD  = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_TICK = 3'd3;
  localparam logic [2:0] ST_MIX  = 3'd4;

  logic [2:0] state;
  logic       accept;

  // Captured command word
  logic [CMD_W-1:0]        cmd_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [LEN_W-1:0]        len_q;
  logic signed [SMP_W-1:0] smp_q;
  logic signed [SMP_W-1:0] ml_q;
  logic signed [SMP_W-1:0] mr_q;

  // Slot table and voice flags
  logic [AW-1:0]    slot_start  [SLOTS];
  logic [LEN_W-1:0] slot_length [SLOTS];
  logic [SLOTS-1:0] slot_valid;
  logic [VOICES-1:0] voice_active;
  logic [CNTW-1:0]   active_count;
  logic [DROP_W-1:0] drop_total;

  // Address reduction
  logic          mod_done;
  logic [AW-1:0] mod_result;

  // Tick pipeline
  logic              iss_on;
  logic [VIW-1:0]    iss_idx;
  logic              s1_valid;
  logic [VIW-1:0]    s1_idx;
  logic              s2_valid;
  logic              s3_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // Memory ports
  logic [AW-1:0]           vm_rd_addr;
  logic [LEN_W-1:0]        vm_rd_rem;
  logic                    vw_en;
  logic [VIW-1:0]          vw_idx;
  logic [AW-1:0]           vw_addr;
  logic [LEN_W-1:0]        vw_rem;
  logic                    sm_wr_en;
  logic signed [SMP_W-1:0] sm_rd_data;

  // Derived signals
  logic [SIW-1:0]    slot_idx;
  logic              slot_ok;
  logic [VOICES-1:0] free_vec;
  logic [VOICES-1:0] free_oh;
  logic [VIW-1:0]    free_idx;
  logic              any_free;
  logic              s1_act;
  logic [AW-1:0]     adv_addr;
  logic [LEN_W-1:0]  rem_dec;
  logic              tick_drained;
  logic signed [ACC_W-1:0] sum_l;
  logic signed [ACC_W-1:0] sum_r;
  logic signed [SMP_W-1:0] clamp_l;
  logic signed [SMP_W-1:0] clamp_r;

  function automatic logic signed [SMP_W-1:0] clamp16(input logic signed [ACC_W-1:0] s);
    logic signed [SHR_W-1:0] q;
    q = SHR_W'(s >>> 16);
    if (q > SHR_W'(32767)) begin
      clamp16 = 16'sh7fff;
    end else if (q < -SHR_W'(32768)) begin
      clamp16 = -16'sh8000;
    end else begin
      clamp16 = q[SMP_W-1:0];
    end
  endfunction

  assign busy          = (state != ST_IDLE);
  assign accept        = start && !busy;
  assign active_voices = ACT_W'(active_count);
  assign dropped_count = drop_total;

  // Slot lookup and lowest free voice
  assign slot_idx = SIW'(slot_q);
  assign slot_ok  = (int'(slot_q) < SLOTS) && slot_valid[slot_idx];
  assign free_vec = ~voice_active;
  assign any_free = |free_vec;
  assign free_oh  = free_vec & (~free_vec + VOICES'(1));

  always_comb begin
    free_idx = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (free_oh[v]) begin
        free_idx = free_idx | VIW'(v);
      end
    end
  end

  // Advance a playing voice by one frame
  assign s1_act   = s1_valid && voice_active[s1_idx];
  assign adv_addr = (vm_rd_addr == AW'(MEM_DEPTH - 1)) ? '0 : vm_rd_addr + AW'(1);
  assign rem_dec  = (vm_rd_rem != '0) ? vm_rd_rem - LEN_W'(1) : vm_rd_rem;
  assign tick_drained = !iss_on && !s1_valid && !s2_valid && !s3_valid;

  // Select the voice-state write: tick write-back or trigger capture
  always_comb begin
    vw_en   = 1'b0;
    vw_idx  = free_idx;
    vw_addr = slot_start[slot_idx];
    vw_rem  = slot_length[slot_idx];
    if (state == ST_TICK && s1_act) begin
      vw_en   = 1'b1;
      vw_idx  = s1_idx;
      vw_addr = adv_addr;
      vw_rem  = rem_dec;
    end else if (state == ST_EXEC && cmd_q == CMD_TRIG && slot_ok && any_free) begin
      vw_en = 1'b1;
    end
  end

  assign sm_wr_en = (state == ST_MOD) && mod_done && (cmd_q == CMD_LOAD);

  // Round half up and clamp both channels
  assign sum_l   = acc + {{(ACC_W-32){ml_q[SMP_W-1]}}, ml_q, 16'h8000};
  assign sum_r   = acc + {{(ACC_W-32){mr_q[SMP_W-1]}}, mr_q, 16'h8000};
  assign clamp_l = clamp16(sum_l);
  assign clamp_r = clamp16(sum_r);

  smix_addr_mod #(
    .MEM_DEPTH(MEM_DEPTH),
    .AW(AW)
  ) u_mod (
    .clk(clk),
    .rst(rst),
    .start(accept),
    .addr_in(address),
    .done(mod_done),
    .result(mod_result)
  );

  smix_sample_mem #(
    .MEM_DEPTH(MEM_DEPTH),
    .AW(AW)
  ) u_smem (
    .clk(clk),
    .wr_en(sm_wr_en),
    .wr_addr(mod_result),
    .wr_data(smp_q),
    .rd_addr(vm_rd_addr),
    .rd_data(sm_rd_data)
  );

  smix_voice_mem #(
    .VOICES(VOICES),
    .AW(AW),
    .VIW(VIW)
  ) u_vmem (
    .clk(clk),
    .wr_en(vw_en),
    .wr_idx(vw_idx),
    .wr_addr(vw_addr),
    .wr_rem(vw_rem),
    .rd_idx(iss_idx),
    .rd_addr(vm_rd_addr),
    .rd_rem(vm_rd_rem)
  );

  // Sequencer, voice flags and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      iss_on       <= 1'b0;
      iss_idx      <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      slot_valid   <= '0;
      voice_active <= '0;
      active_count <= '0;
      drop_total   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q  <= command;
            slot_q <= slot;
            len_q  <= length;
            smp_q  <= sample_value;
            ml_q   <= music_left;
            mr_q   <= music_right;
            if (command == CMD_LOAD || command == CMD_DEFINE) begin
              state <= ST_MOD;
            end else if (command == CMD_TICK) begin
              state   <= ST_TICK;
              iss_on  <= 1'b1;
              iss_idx <= '0;
              acc     <= '0;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            if (cmd_q == CMD_DEFINE && int'(slot_q) < SLOTS) begin
              slot_start[slot_idx]  <= mod_result;
              slot_length[slot_idx] <= len_q;
              slot_valid[slot_idx]  <= (len_q != '0);
            end
            mix_left    <= '0;
            mix_right   <= '0;
            cue_dropped <= 1'b0;
            done        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        ST_EXEC: begin
          cue_dropped <= 1'b0;
          if (cmd_q == CMD_TRIG && slot_ok) begin
            if (any_free) begin
              voice_active[free_idx] <= 1'b1;
              active_count           <= active_count + CNTW'(1);
            end else begin
              cue_dropped <= 1'b1;
              if (drop_total != '1) begin
                drop_total <= drop_total + DROP_W'(1);
              end
            end
          end else if (cmd_q == CMD_CLEAR) begin
            voice_active <= '0;
            active_count <= '0;
          end
          mix_left  <= '0;
          mix_right <= '0;
          done      <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_TICK: begin
          // Issue one voice-state read per cycle
          s1_valid <= iss_on;
          s1_idx   <= iss_idx;
          if (iss_on) begin
            if (iss_idx == VIW'(VOICES - 1)) begin
              iss_on <= 1'b0;
            end else begin
              iss_idx <= iss_idx + VIW'(1);
            end
          end
          // Retire the voice when its last frame is read
          if (s1_act && rem_dec == '0) begin
            voice_active[s1_idx] <= 1'b0;
            active_count         <= active_count - CNTW'(1);
          end
          s2_valid <= s1_act;
          s3_valid <= s2_valid;
          prod     <= sm_rd_data * GAIN_Q16;
          if (s3_valid) begin
            acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
          end
          if (tick_drained) begin
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          mix_left    <= clamp_l;
          mix_right   <= clamp_r;
          cue_dropped <= 1'b0;
          done        <= 1'b1;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/smix_checker.sv @@
module smix_checker #(
  parameter int VOICES = smix_pkg::VOICES_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic                              cue_dropped,
  input logic [smix_pkg::ACT_W-1:0]        active_voices,
  input logic [smix_pkg::DROP_W-1:0]       dropped_count
);
  import smix_pkg::*;

  // An accepted word occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // A result frees the block
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Each result lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  // Drop total never falls outside reset
  a_drop_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> dropped_count >= $past(dropped_count))
    else $error("drop total decreased");

  // A dropped trigger means every voice was playing
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    done && cue_dropped |-> active_voices == ACT_W'(VOICES))
    else $error("trigger dropped with a free voice");

endmodule

bind sample_voice_allocator_mixer smix_checker #(
  .VOICES(VOICES)
) u_smix_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .cue_dropped(cue_dropped),
  .active_voices(active_voices),
  .dropped_count(dropped_count)
);
